// ===== sv/lfsd_pkg.sv =====
// Shared types and constants for the length-framed, sum-checked deframer.
// Used by the front classifier, the item queue, the back sequencer and the top level.
// No dependencies.
`default_nettype none

package lfsd_pkg;

  // Widths fixed by the frame format.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_HEADER  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd2;

  // Configuration reset values.
  localparam logic [ByteW-1:0] HeaderReset  = 8'hFE;
  localparam logic [ByteW-1:0] MaxLenReset  = 8'd99;
  localparam logic [ByteW-1:0] TimeoutReset = 8'd100;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_BYTE    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD     = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_LENBAD  = 3'd4
  } status_e;

  // Receive phase, one-hot.
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_DATA = 4'b0100,
    PH_SUM  = 4'b1000
  } phase_e;

  // One classified input item as it travels from the front to the back.
  typedef struct packed {
    logic             is_tick;
    logic             hdr_hit;
    logic             len_zero;
    logic             len_over;
    logic [ByteW-1:0] data;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/lfsd_front.sv =====
// Front end of the deframer: accepts input transfers and classifies each byte
// against the header value and the length limit. Depends on lfsd_pkg.
`default_nettype none

module lfsd_front (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic [lfsd_pkg::ByteW-1:0]  rx_byte_i,
  input  logic [lfsd_pkg::ByteW-1:0]  header_i,
  input  logic [lfsd_pkg::ByteW-1:0]  max_len_i,
  input  logic                        q_ready_i,
  output logic                        q_push_o,
  output lfsd_pkg::item_t             q_item_o
);
  import lfsd_pkg::*;

  // An item is taken whenever the queue has room.
  assign in_ready_o = q_ready_i;
  assign q_push_o   = in_valid_i & q_ready_i;

  // Precompute the header and length comparisons the back needs; the checksum compare stays in the back.
  always_comb begin
    q_item_o.is_tick  = mode_i;
    q_item_o.hdr_hit  = (rx_byte_i == header_i);
    q_item_o.len_zero = (rx_byte_i == '0);
    q_item_o.len_over = (rx_byte_i > max_len_i);
    q_item_o.data     = rx_byte_i;
  end

endmodule

`default_nettype wire

// ===== sv/lfsd_queue.sv =====
// Short FIFO of classified items between the front and the back of the deframer.
// Depends on lfsd_pkg for the item type and the depth.
`default_nettype none

module lfsd_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lfsd_pkg::item_t               push_item_i,
  output logic                          ready_o,
  input  logic                          pop_i,
  output logic                          valid_o,
  output lfsd_pkg::item_t               head_o,
  output logic [lfsd_pkg::QCntW-1:0]    count_o
);
  import lfsd_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign ready_o = (count_q != QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

  // Pointer and fill count update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Item storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfsd_back.sv =====
// Back end of the deframer: the frame sequencer, checksum, tick timeout and
// the registered result stage. Depends on lfsd_pkg.
`default_nettype none

module lfsd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lfsd_pkg::ByteW-1:0]    timeout_i,
  input  logic                          q_valid_i,
  input  lfsd_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lfsd_pkg::StatusW-1:0]  status_o,
  output logic [lfsd_pkg::ByteW-1:0]    payload_byte_o,
  output logic                          frame_end_o
);
  import lfsd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] remain_q, remain_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] tick_q, tick_d;
  logic [ByteW-1:0] tick_inc;

  logic             res_valid;
  status_e          res_status;
  logic [ByteW-1:0] res_byte;
  logic             res_end;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_end_q;

  // Take the next item when the result register is free or being drained.
  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  // Saturating tick counter increment.
  assign tick_inc = (tick_q != '1) ? tick_q + 1'b1 : tick_q;

  // Frame sequencer.
  always_comb begin
    phase_d    = phase_q;
    remain_d   = remain_q;
    sum_d      = sum_q;
    tick_d     = tick_q;
    res_valid  = 1'b0;
    res_status = ST_BYTE;
    res_byte   = '0;
    res_end    = 1'b0;
    if (q_pop_o) begin
      if (q_item_i.is_tick) begin
        // Ticks only count while a frame is open.
        if (phase_q != PH_HUNT) begin
          if (tick_inc >= timeout_i) begin
            tick_d     = '0;
            remain_d   = '0;
            phase_d    = PH_HUNT;
            res_valid  = 1'b1;
            res_status = ST_TIMEOUT;
            res_end    = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
      end else begin
        case (phase_q)
          PH_HUNT: begin
            if (q_item_i.hdr_hit) begin
              phase_d = PH_LEN;
              tick_d  = '0;
            end
          end
          PH_LEN: begin
            if (q_item_i.len_zero) begin
              phase_d = PH_HUNT;
            end else if (q_item_i.len_over) begin
              phase_d    = PH_HUNT;
              remain_d   = '0;
              res_valid  = 1'b1;
              res_status = ST_LENBAD;
              res_end    = 1'b1;
            end else begin
              remain_d = q_item_i.data;
              sum_d    = '0;
              phase_d  = PH_DATA;
            end
          end
          PH_DATA: begin
            sum_d     = sum_q + q_item_i.data;
            remain_d  = remain_q - 1'b1;
            if (remain_q == ByteW'(1)) begin
              phase_d = PH_SUM;
            end
            res_valid = 1'b1;
            res_byte  = q_item_i.data;
          end
          PH_SUM: begin
            phase_d    = PH_HUNT;
            res_valid  = 1'b1;
            res_status = (q_item_i.data == sum_q) ? ST_GOOD : ST_BAD;
            res_end    = 1'b1;
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      remain_q <= '0;
      sum_q    <= '0;
      tick_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      sum_q    <= sum_d;
      tick_q   <= tick_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_valid) begin
      out_status_q <= res_status;
      out_byte_q   <= res_byte;
      out_end_q    <= res_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign payload_byte_o = out_byte_q;
  assign frame_end_o    = out_end_q;

endmodule

`default_nettype wire

// ===== sv/length_framed_sum_checked_deframer_unit.sv =====
// Top level of the length-framed, sum-checked deframer: configuration registers,
// front classifier, item queue and back sequencer. Depends on lfsd_pkg and all lfsd_ modules.
`default_nettype none

// The block takes one input transfer (a received byte or a poll tick) per clock while
// its queue has room, and gives at most one result per item, in order. A front stage
// compares each byte with the header value and the length limit and pushes it into a
// two-entry queue; the back sequencer pops one item per cycle while the result register
// is free or being drained, updates the phase, length, checksum and tick counters, and
// loads the result register. With nothing waiting ahead of it, an item passes through
// the queue register and then the result register before its result is presented. Full
// throughput of one item per cycle holds while the result side keeps taking results;
// the single sequencer step per item is what sets that rate. Items that give no result
// (headers, length bytes, ticks outside a timeout) still take a sequencer step.
// Configuration writes are taken at once and must only happen while the block is idle.
module length_framed_sum_checked_deframer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lfsd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [lfsd_pkg::ByteW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [lfsd_pkg::ByteW-1:0]     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [lfsd_pkg::StatusW-1:0]   status_o,
  output logic [lfsd_pkg::ByteW-1:0]     payload_byte_o,
  output logic                           frame_end_o
);
  import lfsd_pkg::*;

  logic [ByteW-1:0] header_q;
  logic [ByteW-1:0] max_len_q;
  logic [ByteW-1:0] timeout_q;

  logic             q_ready;
  logic             q_push;
  item_t            q_push_item;
  logic             q_pop;
  logic             q_valid;
  item_t            q_head;
  logic [QCntW-1:0] q_count;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HeaderReset;
      max_len_q <= MaxLenReset;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER:  header_q  <= cfg_wdata_i;
        CFG_MAX_LEN: max_len_q <= cfg_wdata_i;
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front classifier.
  lfsd_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .rx_byte_i  (rx_byte_i),
    .header_i   (header_q),
    .max_len_i  (max_len_q),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_item_o   (q_push_item)
  );

  // Queue between front and back.
  lfsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .count_o     (q_count)
  );

  // Back sequencer and result register.
  lfsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .timeout_i      (timeout_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o)
  );

`ifndef SYNTHESIS
  // The front stalls only when the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (q_count == QCntW'(QueueDepth)))
    else $error("input stalled while queue has room");

  // A payload byte result never closes a frame; every other status does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (status_o != ST_BYTE)))
    else $error("frame_end does not match status");

  // The payload field is zero on every non-payload result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_BYTE)) |-> (payload_byte_o == '0))
    else $error("payload byte set on a verdict result");

  // A pop without a free result register would overwrite a pending result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && out_valid_o) |-> out_ready_i)
    else $error("sequencer advanced while result stalled");
`endif

endmodule

`default_nettype wire

// ===== tb/lfsd_frame_checker.sv =====
// Scoreboard for the length-framed, sum-checked deframer: follows every transfer
// and configuration write, predicts the results and compares them in order.
// Depends on lfsd_pkg.
module lfsd_frame_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lfsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfsd_pkg::ByteW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         mode_i,
  input  logic [lfsd_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [lfsd_pkg::StatusW-1:0] status_i,
  input  logic [lfsd_pkg::ByteW-1:0]   payload_byte_i,
  input  logic                         frame_end_i,
  output int unsigned                  due_count_o,
  output int unsigned                  fail_count_o
);
  import lfsd_pkg::*;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] payload;
    logic             frame_end;
  } frame_result_t;

  // Shadow copy of the configuration registers.
  logic [ByteW-1:0] cfg_header;
  logic [ByteW-1:0] cfg_max_len;
  logic [ByteW-1:0] cfg_timeout;

  // Shadow copy of the receive state.
  phase_e           rx_phase;
  logic [ByteW-1:0] bytes_left;
  logic [ByteW-1:0] frame_sum;
  logic [ByteW-1:0] tick_cnt;

  frame_result_t results_due[$];
  int unsigned   mismatches;

  // Advances the shadow state by one accepted item and queues the result it gives.
  task automatic predict_frame_result(input logic is_tick, input logic [ByteW-1:0] b);
    if (is_tick) begin
      // Ticks only count while a frame is open; the count saturates.
      if (rx_phase != PH_HUNT) begin
        if (tick_cnt != 8'hFF) tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= cfg_timeout) begin
          tick_cnt   = '0;
          bytes_left = '0;
          rx_phase   = PH_HUNT;
          results_due.push_back('{status: ST_TIMEOUT, payload: 8'h00, frame_end: 1'b1});
        end
      end
    end else begin
      case (rx_phase)
        PH_HUNT: begin
          if (b == cfg_header) begin
            rx_phase = PH_LEN;
            tick_cnt = '0;
          end
        end
        PH_LEN: begin
          if (b == 8'h00) begin
            rx_phase = PH_HUNT;
          end else if (b > cfg_max_len) begin
            rx_phase   = PH_HUNT;
            bytes_left = '0;
            results_due.push_back('{status: ST_LENBAD, payload: 8'h00, frame_end: 1'b1});
          end else begin
            bytes_left = b;
            frame_sum  = '0;
            rx_phase   = PH_DATA;
          end
        end
        PH_DATA: begin
          frame_sum  = frame_sum + b;
          bytes_left = bytes_left - 8'd1;
          if (bytes_left == 8'h00) rx_phase = PH_SUM;
          results_due.push_back('{status: ST_BYTE, payload: b, frame_end: 1'b0});
        end
        default: begin
          rx_phase = PH_HUNT;
          results_due.push_back('{status: (b == frame_sum) ? ST_GOOD : ST_BAD,
                                  payload: 8'h00, frame_end: 1'b1});
        end
      endcase
    end
  endtask

  // Results are checked before the item of the same edge is predicted, so a stray
  // result can never be matched against an expectation it could not have caused.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    frame_result_t want;
    if (!rst_ni) begin
      cfg_header   = HeaderReset;
      cfg_max_len  = MaxLenReset;
      cfg_timeout  = TimeoutReset;
      rx_phase     = PH_HUNT;
      bytes_left   = '0;
      frame_sum    = '0;
      tick_cnt     = '0;
      mismatches   = 0;
      results_due.delete();
      due_count_o  <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          $error("result with none awaited: status %0d, payload_byte %0d, frame_end %0d",
                 status_i, payload_byte_i, frame_end_i);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            mismatches++;
          end
          if (payload_byte_i !== want.payload) begin
            $error("payload_byte: expected %0d, actual %0d", want.payload, payload_byte_i);
            mismatches++;
          end
          if (frame_end_i !== want.frame_end) begin
            $error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && in_ready_i) predict_frame_result(mode_i, rx_byte_i);

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEADER:  cfg_header  = cfg_wdata_i;
          CFG_MAX_LEN: cfg_max_len = cfg_wdata_i;
          CFG_TIMEOUT: cfg_timeout = cfg_wdata_i;
          default: ;
        endcase
      end

      due_count_o  <= results_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/length_framed_sum_checked_deframer_unit_test.sv =====
// Stimulus and verdict for the length-framed, sum-checked deframer: directed frames,
// then random framed traffic under several register settings, with paced handshakes.
// Depends on lfsd_pkg, the deframer top level and lfsd_frame_checker.
module length_framed_sum_checked_deframer_unit_test;
  import lfsd_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned SqueezeCycles = 200;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ByteW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               mode_i;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [StatusW-1:0] status_o;
  logic [ByteW-1:0]   payload_byte_o;
  logic               frame_end_o;

  int unsigned due_count;
  int unsigned mismatch_count;

  // Settings currently loaded, used to shape the traffic.
  logic [ByteW-1:0] cur_hdr;
  logic [ByteW-1:0] cur_max;
  logic [ByteW-1:0] cur_tmo;

  int unsigned items_sent;
  int unsigned burst_left;
  logic        squeeze_req;
  logic        squeeze_done;
  int unsigned idle_cycles;

  length_framed_sum_checked_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .payload_byte_o (payload_byte_o),
    .frame_end_o    (frame_end_o)
  );

  lfsd_frame_checker frame_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .payload_byte_i (payload_byte_o),
    .frame_end_i    (frame_end_o),
    .due_count_o    (due_count),
    .fail_count_o   (mismatch_count)
  );

  // Clock with a period of 4.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one item and waits for its transfer. Items come in bursts; valid is
  // dropped only when a gap opens, so back-to-back items keep it high.
  task automatic send_item(input logic is_tick, input logic [ByteW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= is_tick;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Writes all three registers back to back while the block is idle.
  task automatic load_settings(input logic [ByteW-1:0] hdr, input logic [ByteW-1:0] max_len,
                               input logic [ByteW-1:0] tmo);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HEADER;
    cfg_wdata_i <= hdr;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAX_LEN;
    cfg_wdata_i <= max_len;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TIMEOUT;
    cfg_wdata_i <= tmo;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_hdr = hdr;
    cur_max = max_len;
    cur_tmo = tmo;
  endtask

  // Stops offering, waits for every awaited result, then lets silent items flush.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly well-formed frames with random content; the rest is loose bytes,
  // stray ticks, empty and oversized lengths and frames left to time out.
  task automatic run_traffic(input int unsigned quota);
    int unsigned start;
    int unsigned lim;
    int unsigned len;
    int unsigned cut;
    int unsigned ticks;
    int unsigned i;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    start = items_sent;
    while (items_sent - start < quota) begin
      lim = (cur_max == 8'h00) ? 1 : cur_max;
      if ($urandom_range(0, 19) == 0) len = lim;
      else len = $urandom_range(1, (lim < 10) ? lim : 10);
      if ($urandom_range(0, 9) < 7) begin
        send_item(1'b0, cur_hdr);
        send_item(1'b0, 8'(len));
        sum = '0;
        for (i = 0; i < len; i++) begin
          if ($urandom_range(0, 11) == 0) send_item(1'b1, 8'($urandom));
          b = 8'($urandom);
          sum = sum + b;
          send_item(1'b0, b);
        end
        if ($urandom_range(0, 11) == 0) send_item(1'b1, 8'($urandom));
        // Roughly one frame in four carries a wrong checksum.
        if ($urandom_range(0, 3) == 0) sum = sum + 8'($urandom_range(1, 255));
        send_item(1'b0, sum);
      end else begin
        case ($urandom_range(0, 4))
          0: send_item(1'b0, 8'($urandom));
          1: send_item(1'b1, 8'($urandom));
          2: begin
            send_item(1'b0, cur_hdr);
            send_item(1'b0, 8'h00);
          end
          3: begin
            send_item(1'b0, cur_hdr);
            if (cur_max == 8'hFF) send_item(1'b0, 8'h00);
            else send_item(1'b0, 8'($urandom_range(cur_max + 1, 255)));
          end
          default: begin
            // Frame cut short and closed by the timeout.
            len = $urandom_range(1, (lim < 10) ? lim : 10);
            send_item(1'b0, cur_hdr);
            send_item(1'b0, 8'(len));
            cut = $urandom_range(0, len);
            for (i = 0; i < cut; i++) send_item(1'b0, 8'($urandom));
            ticks = ((cur_tmo == 8'h00) ? 1 : cur_tmo) + $urandom_range(0, 2);
            for (i = 0; i < ticks; i++) send_item(1'b1, 8'($urandom));
          end
        endcase
      end
    end
  endtask

  // Result side: segments of different stall patterns, and once a long hold-off
  // while the sender keeps offering, so the block fills and stalls its input.
  initial begin : result_sink
    int unsigned span;
    int unsigned style;
    int unsigned k;
    squeeze_done = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (SqueezeCycles) @(posedge clk_i);
      end else begin
        style = $urandom_range(0, 4);
        span  = $urandom_range(8, 60);
        for (k = 0; k < span; k++) begin
          case (style)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            2: out_ready_i <= (k % 4 == 0);
            3: out_ready_i <= ($urandom_range(0, 9) != 0);
            default: out_ready_i <= (k >= span / 2);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Ends the run when nothing has been transferred for too long.
  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // Main sequence: reset, directed frames, then random traffic per setting.
  initial begin : stimulus
    int unsigned ph;
    items_sent  = 0;
    burst_left  = 0;
    squeeze_req <= 1'b0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_HEADER;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    mode_i      <= 1'b0;
    rx_byte_i   <= '0;
    cur_hdr = HeaderReset;
    cur_max = MaxLenReset;
    cur_tmo = TimeoutReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings.
    // A tick and extreme bytes while hunting are ignored.
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    // Zero length goes back to hunting silently.
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'h00);
    // One above the limit, and the largest length, are both invalid.
    send_item(1'b0, HeaderReset);
    send_item(1'b0, MaxLenReset + 8'd1);
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'hFF);
    // The header value inside a frame is plain data; good checksum.
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'd2);
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, HeaderReset + 8'hFF);
    // Bad checksum on a single zero byte.
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'd1);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h01);
    // A tick inside a frame below the timeout changes nothing.
    send_item(1'b0, HeaderReset);
    send_item(1'b0, 8'd1);
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h55);
    send_item(1'b0, 8'h55);
    drain();

    // Random traffic under several settings, extremes included. The zero
    // settings make every nonzero length invalid and abort on the first tick.
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: load_settings(8'h00, 8'hFF, 8'hFF);
        1: load_settings(8'hFF, 8'h01, 8'h01);
        2: load_settings(8'hA5, 8'h06, 8'h03);
        3: load_settings(8'h3C, 8'h00, 8'h00);
        default: load_settings(8'($urandom), 8'($urandom_range(1, 16)),
                               8'($urandom_range(4, 40)));
      endcase
      if (ph == 2) squeeze_req <= 1'b1;
      run_traffic((ph == 3) ? 120 : 210);
      drain();
    end

    if (mismatch_count == 0 && due_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/lfsd_pkg.sv
sv/lfsd_front.sv
sv/lfsd_queue.sv
sv/lfsd_back.sv
sv/length_framed_sum_checked_deframer_unit.sv
tb/lfsd_frame_checker.sv
tb/length_framed_sum_checked_deframer_unit_test.sv
